/* design/crts_pkg.sv */
// Shared types, widths and codes for the Catmull-Rom trail subdivider.
// No dependencies; every other design file imports this package.
package crts_pkg;

   // Configuration and widths.
   localparam int          MAX_DIVISIONS_DEF = 16;
   localparam int          DIV_COUNT_W       = 5;
   localparam logic [4:0]  DIV_COUNT_RESET   = 5'd4;
   localparam int          COORD_W           = 32;
   localparam int          AXIS_W            = 16;
   // Horner accumulator: coefficients stay below 26 * 2^31 in magnitude.
   localparam int          ACC_W             = 37;
   // Weight t in Q0.16, one spare bit for the running sum.
   localparam int          T_W               = 17;
   localparam int          T_FRAC            = 16;
   // Restoring division of 2^16 by N+1, one quotient bit per cycle.
   localparam int          RECIP_STEPS       = 17;
   localparam int          RECIP_CNT_W       = 5;
   localparam int          CSR_ADDR_W        = 3;
   localparam int          CSR_DATA_W        = 32;
   localparam logic [2:0]  FILL_FULL         = 3'd4;

   // Register index codes.
   localparam logic        REG_DIVISION_COUNT = 1'b0;

   // Horner step codes.
   localparam logic [1:0]  STEP_CUBIC = 2'd0;
   localparam logic [1:0]  STEP_QUAD  = 2'd1;
   localparam logic [1:0]  STEP_LIN   = 2'd2;
   localparam logic [1:0]  STEP_AXIS  = 2'd3;

   // Coordinate codes.
   localparam logic [1:0]  COORD_X = 2'd0;
   localparam logic [1:0]  COORD_Y = 2'd1;
   localparam logic [1:0]  COORD_Z = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [AXIS_W-1:0]  axis_x;
      logic signed [AXIS_W-1:0]  axis_y;
      logic signed [AXIS_W-1:0]  axis_z;
      logic                      restart;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic signed [AXIS_W-1:0]  out_axis_x;
      logic signed [AXIS_W-1:0]  out_axis_y;
      logic signed [AXIS_W-1:0]  out_axis_z;
      logic                      last_of_run;
   } rsp_item_type;

   // Controls of the shared multiply-accumulate unit.
   typedef struct packed {
      logic load_mul;
      logic load_acc;
   } mac_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_TSTEP,
      ST_MUL,
      ST_ACC,
      ST_CAP,
      ST_OUT
   } seq_state_type;

endpackage

/* design/catmull_rom_trail_subdivider_unit.sv */
// Top level of the Catmull-Rom trail subdivider: point window, sequencer, CSR.
// Depends on crts_pkg, crts_recip and crts_mac.
//
//  channel | ports                      | direction | payload
//  --------+----------------------------+-----------+----------------
//  request | req_valid req_stall req_data | in      | req_item_type
//  result  | rsp_valid rsp_stall rsp_data | out     | rsp_item_type
//  config  | csr_psel .. csr_prdata     | in/out    | division_count
//
// A point that fills no window, or comes while the division count is zero,
// yields no result. Otherwise the item runs the serial reciprocal, then the
// coefficients, then 12 multiply-add passes per result through the one shared MAC.
// req_stall stays high until the last result of the item is taken.
// A stalled result holds in the output register. Reset is synchronous.
module catmull_rom_trail_subdivider_unit import crts_pkg::*; #(
   parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int NW = $clog2(MAX_DIVISIONS + 1);
   localparam int DW = $clog2(MAX_DIVISIONS + 2);

   seq_state_type state_ff, state_in;

   logic [DIV_COUNT_W-1:0]  dc_ff;
   logic signed [COORD_W-1:0] pwin_ff [12];
   logic signed [AXIS_W-1:0]  awin_ff [9];
   logic [2:0]              fill_ff, fill_in;
   logic [NW-1:0]           n_ff, n_comb, j_ff;
   logic [1:0]              c_ff, s_ff;
   logic [T_W-1:0]          t_ff;
   logic [DW-1:0]           r_ff, d_run, d_comb;
   logic [DW:0]             rsum;
   logic signed [ACC_W-1:0] c3_ff [3];
   logic signed [ACC_W-1:0] c2_ff [3];
   logic signed [ACC_W-1:0] c1_ff [3];
   logic signed [ACC_W-1:0] c0_ff [3];
   logic signed [ACC_W-1:0] axb_ff [3];
   logic signed [ACC_W-1:0] axd_ff [3];
   rsp_item_type            rsp_ff;

   logic                    accept, rsp_take, will_run, div_start, div_done;
   logic [T_W-1:0]          quot;
   logic [DW-1:0]           rem;
   mac_ctrl_type            mac_ctrl;
   logic signed [ACC_W-1:0] mul_op, addend, acc;
   logic signed [ACC_W-1:0] e0, e1, e2, e3, hr;
   logic signed [COORD_W-1:0] pos_sat;
   logic                    csr_wr;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_DIVISION_COUNT) ?
                       CSR_DATA_W'(dc_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff <= DIV_COUNT_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_DIVISION_COUNT) begin
         dc_ff <= csr_pwdata[DIV_COUNT_W-1:0];
      end
   end

   // Effective division count and its divisor N+1.
   always_comb begin
      if (32'(dc_ff) > MAX_DIVISIONS) begin
         n_comb = NW'(MAX_DIVISIONS);
      end else begin
         n_comb = NW'(dc_ff);
      end
      d_comb = DW'(n_comb) + DW'(1);
      d_run  = DW'(n_ff) + DW'(1);
   end

   // Window fill after this point.
   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   always_comb begin
      if (req_data.restart) begin
         fill_in = 3'd1;
      end else if (fill_ff < FILL_FULL) begin
         fill_in = fill_ff + 3'd1;
      end else begin
         fill_in = FILL_FULL;
      end
      will_run = (fill_in == FILL_FULL) && (n_comb != '0);
   end

   crts_recip #(.DW(DW)) u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (d_run),
      .done    (div_done),
      .quot    (quot),
      .rem     (rem)
   );

   crts_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .mul_op (mul_op),
      .tval   (t_ff),
      .addend (addend),
      .acc    (acc)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && will_run) state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_PREP;
         ST_PREP:  if (c_ff == COORD_Z) state_in = ST_TSTEP;
         ST_TSTEP: state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = (s_ff == STEP_AXIS) ? ST_CAP : ST_MUL;
         ST_CAP:   state_in = (c_ff == COORD_Z) ? ST_OUT : ST_MUL;
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = rsp_ff.last_of_run ? ST_IDLE : ST_TSTEP;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall         = (state_ff != ST_IDLE);
      rsp_valid         = (state_ff == ST_OUT);
      div_start         = (state_ff == ST_IDLE) && accept && will_run;
      mac_ctrl.load_mul = (state_ff == ST_MUL);
      mac_ctrl.load_acc = (state_ff == ST_ACC);
      case (s_ff)
         STEP_CUBIC: begin
            mul_op = c3_ff[c_ff];
            addend = c2_ff[c_ff];
         end
         STEP_QUAD: begin
            mul_op = acc;
            addend = c1_ff[c_ff];
         end
         STEP_LIN: begin
            mul_op = acc;
            addend = c0_ff[c_ff];
         end
         STEP_AXIS: begin
            mul_op = axd_ff[c_ff];
            addend = axb_ff[c_ff];
         end
         default: begin
            mul_op = acc;
            addend = acc;
         end
      endcase
   end

   // Coefficients from the fixed slots; the window rotates coordinates in.
   always_comb begin
      e0 = ACC_W'(pwin_ff[9]);
      e1 = ACC_W'(pwin_ff[6]);
      e2 = ACC_W'(pwin_ff[3]);
      e3 = ACC_W'(pwin_ff[0]);
   end

   // Final halving with rounding, then saturation to 32 bits.
   always_comb begin
      hr = (acc + ACC_W'(1)) >>> 1;
      if (!hr[ACC_W-1] && (|hr[ACC_W-2:COORD_W-1])) begin
         pos_sat = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (hr[ACC_W-1] && !(&hr[ACC_W-2:COORD_W-1])) begin
         pos_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         pos_sat = hr[COORD_W-1:0];
      end
   end

   assign rsum = {1'b0, r_ff} + {1'b0, rem};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   // Window, counters and datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               for (int k = 3; k < 12; k++) begin
                  pwin_ff[k] <= req_data.restart ? '0 : pwin_ff[k-3];
               end
               for (int k = 3; k < 9; k++) begin
                  awin_ff[k] <= req_data.restart ? '0 : awin_ff[k-3];
               end
               pwin_ff[0] <= req_data.pos_x;
               pwin_ff[1] <= req_data.pos_y;
               pwin_ff[2] <= req_data.pos_z;
               awin_ff[0] <= req_data.axis_x;
               awin_ff[1] <= req_data.axis_y;
               awin_ff[2] <= req_data.axis_z;
               n_ff <= n_comb;
               j_ff <= '0;
               c_ff <= COORD_X;
               s_ff <= STEP_CUBIC;
               t_ff <= '0;
               r_ff <= d_comb >> 1;
            end
         end
         ST_PREP: begin
            c3_ff[c_ff]  <= e3 - e0 + 3 * (e1 - e2);
            c2_ff[c_ff]  <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
            c1_ff[c_ff]  <= e2 - e0;
            c0_ff[c_ff]  <= 2 * e1;
            axb_ff[c_ff] <= ACC_W'(awin_ff[6]);
            axd_ff[c_ff] <= ACC_W'(awin_ff[3]) - ACC_W'(awin_ff[6]);
            // Three rotations bring every point back to its own order.
            for (int k = 0; k < 4; k++) begin
               pwin_ff[3*k]   <= pwin_ff[3*k+1];
               pwin_ff[3*k+1] <= pwin_ff[3*k+2];
               pwin_ff[3*k+2] <= pwin_ff[3*k];
            end
            for (int k = 0; k < 3; k++) begin
               awin_ff[3*k]   <= awin_ff[3*k+1];
               awin_ff[3*k+1] <= awin_ff[3*k+2];
               awin_ff[3*k+2] <= awin_ff[3*k];
            end
            c_ff <= (c_ff == COORD_Z) ? COORD_X : c_ff + 2'd1;
         end
         ST_TSTEP: begin
            // Next weight: add the quotient and fold the remainder once.
            if (rsum >= {1'b0, d_run}) begin
               r_ff <= DW'(rsum - {1'b0, d_run});
               t_ff <= t_ff + quot + T_W'(1);
            end else begin
               r_ff <= DW'(rsum);
               t_ff <= t_ff + quot;
            end
            c_ff <= COORD_X;
            s_ff <= STEP_CUBIC;
            rsp_ff.last_of_run <= (j_ff == n_ff - NW'(1));
         end
         ST_MUL: begin
            if (s_ff == STEP_AXIS) begin
               case (c_ff)
                  COORD_X: rsp_ff.out_x <= pos_sat;
                  COORD_Y: rsp_ff.out_y <= pos_sat;
                  default: rsp_ff.out_z <= pos_sat;
               endcase
            end
         end
         ST_ACC: begin
            s_ff <= s_ff + 2'd1;
         end
         ST_CAP: begin
            case (c_ff)
               COORD_X: rsp_ff.out_axis_x <= acc[AXIS_W-1:0];
               COORD_Y: rsp_ff.out_axis_y <= acc[AXIS_W-1:0];
               default: rsp_ff.out_axis_z <= acc[AXIS_W-1:0];
            endcase
            c_ff <= (c_ff == COORD_Z) ? COORD_X : c_ff + 2'd1;
         end
         ST_OUT: begin
            if (rsp_take) begin
               j_ff <= j_ff + NW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

/* design/crts_recip.sv */
// Bit-serial restoring divider that forms floor(2^16 / d) and 2^16 mod d.
// Depends on crts_pkg for the step count and weight width.
module crts_recip import crts_pkg::*; #(
   parameter int DW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [T_W-1:0] quot,
   output logic [DW-1:0] rem
);

   logic [DW-1:0]          rem_ff, rem_in;
   logic [T_W-1:0]         quot_ff, quot_in;
   logic [RECIP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DW:0]            trial;
   logic                   dbit;

   // One quotient bit per cycle; the dividend is a single one in its top bit.
   always_comb begin
      dbit    = (cnt_ff == RECIP_CNT_W'(RECIP_STEPS));
      trial   = {rem_ff, dbit};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = RECIP_CNT_W'(RECIP_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in  = DW'(trial - {1'b0, divisor});
            quot_in = {quot_ff[T_W-2:0], 1'b1};
         end else begin
            rem_in  = DW'(trial);
            quot_in = {quot_ff[T_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - RECIP_CNT_W'(1);
         if (cnt_ff == RECIP_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

/* design/crts_mac.sv */
// Shared multiply-accumulate unit: acc = addend + round(op * t / 2^16).
// Depends on crts_pkg for widths and the control struct.
module crts_mac import crts_pkg::*; (
   input  logic                    clock,
   input  mac_ctrl_type            ctrl,
   input  logic signed [ACC_W-1:0] mul_op,
   input  logic [T_W-1:0]          tval,
   input  logic signed [ACC_W-1:0] addend,
   output logic signed [ACC_W-1:0] acc
);

   localparam int PW = ACC_W + T_W + 1;

   logic signed [PW-1:0]        prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [PW-T_FRAC-1:0] shifted;
   logic signed [ACC_W-1:0]     carry;

   // Multiply phase: the product is registered before the add.
   assign prod_in = mul_op * $signed({1'b0, tval});

   // Add phase: rounding half up is the top dropped bit as a carry in.
   assign shifted = prod_ff[PW-1:T_FRAC];
   assign carry   = $signed({{(ACC_W-1){1'b0}}, prod_ff[T_FRAC-1]});
   assign acc_in  = addend + ACC_W'(shifted) + carry;

   always_ff @(posedge clock) begin
      if (ctrl.load_mul) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load_acc) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* design/crts_checker.sv */
// Port-level checks for the trail subdivider, bound to the top level.
// Depends on crts_pkg for the result item type.
module crts_checker import crts_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // No new point is taken while a result waits.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // A result never shows the cycle after a point is taken.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result appeared right after a point");

   // Results of one segment are spaced by the shared unit's passes.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("results issued back to back");

endmodule

bind catmull_rom_trail_subdivider_unit crts_checker u_crts_checker (.*);
